/* rtl/mcos_pkg.sv */
// shared types, constants and register indexes of the min cost offer select unit
package mcos_pkg;

    // field widths
    localparam int UNIT_W   = 8;
    localparam int PRICE_W  = 16;
    localparam int AMOUNT_W = 16;
    localparam int COST_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int REQN_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;

    // default configuration of the design
    localparam int MAX_REQUESTS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // cost value reported when no resource qualified
    localparam logic [COST_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'd255;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQUEST_COUNT = 3'd0,
        REG_REQ0_UNIT     = 3'd1,
        REG_REQ0_AMOUNT   = 3'd2,
        REG_REQ1_UNIT     = 3'd3,
        REG_REQ1_AMOUNT   = 3'd4,
        REG_REQ2_UNIT     = 3'd5,
        REG_REQ2_AMOUNT   = 3'd6
    } cfg_reg_t;

    // register index of each request slot
    localparam cfg_reg_t REQ_UNIT_INDEX [3] = '{REG_REQ0_UNIT, REG_REQ1_UNIT, REG_REQ2_UNIT};
    localparam cfg_reg_t REQ_AMOUNT_INDEX [3] =
        '{REG_REQ0_AMOUNT, REG_REQ1_AMOUNT, REG_REQ2_AMOUNT};

    // classified attribute handed from front to back
    typedef struct packed {
        logic [COST_W-1:0] cost_delta;
        logic [REQN_W-1:0] match_num;
        logic              resource_end;
        logic              database_end;
    } queue_item_t;

endpackage

/* rtl/mcos_front.sv */
// front part: configuration registers, request matching and cost products
module mcos_front
    import mcos_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [UNIT_W-1:0]     offer_unit,
    input  logic [PRICE_W-1:0]    offer_price,
    input  logic [AMOUNT_W-1:0]   offer_amount,
    input  logic                  resource_end,
    input  logic                  database_end,
    output logic                  push,
    output queue_item_t           push_item,
    input  logic                  queue_full,
    output logic [REQN_W-1:0]     active_count
);

    logic [REQN_W-1:0]   request_count_reg;
    logic [UNIT_W-1:0]   req_unit_reg   [MAX_REQUESTS];
    logic [AMOUNT_W-1:0] req_amount_reg [MAX_REQUESTS];

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [COST_W-1:0]   s1_prod_reg [MAX_REQUESTS];
    logic [REQN_W-1:0]   s1_match_num_reg;
    logic                s1_resource_end_reg;
    logic                s1_database_end_reg;

    logic [MAX_REQUESTS-1:0] lane_match;
    logic [COST_W-1:0]       lane_prod [MAX_REQUESTS];
    logic [REQN_W-1:0]       match_num;
    logic [COST_W-1:0]       delta_sum;
    logic                    accept;

    // request count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_count_reg <= 2'd1;
        end
        else if (cfg_we && cfg_addr == REG_REQUEST_COUNT)
        begin
            request_count_reg <= cfg_wdata[REQN_W-1:0];
        end
    end

    // clamp to the number of request slots built
    assign active_count = (request_count_reg > REQN_W'(MAX_REQUESTS)) ?
                          REQN_W'(MAX_REQUESTS) : request_count_reg;

    // one matching lane per request slot
    for (genvar i = 0; i < MAX_REQUESTS; i++)
    begin : g_lane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                req_unit_reg[i]   <= '0;
                req_amount_reg[i] <= '0;
            end
            else if (cfg_we)
            begin
                if (cfg_addr == REQ_UNIT_INDEX[i])
                begin
                    req_unit_reg[i] <= cfg_wdata[UNIT_W-1:0];
                end
                if (cfg_addr == REQ_AMOUNT_INDEX[i])
                begin
                    req_amount_reg[i] <= cfg_wdata[AMOUNT_W-1:0];
                end
            end
        end

        // active slot with equal unit and enough amount on offer
        assign lane_match[i] = (REQN_W'(i) < active_count) &&
                               (req_unit_reg[i] == offer_unit) &&
                               (req_amount_reg[i] <= offer_amount);
        assign lane_prod[i]  = lane_match[i] ?
                               COST_W'(req_amount_reg[i]) * COST_W'(offer_price) : '0;

        // product register
        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                s1_prod_reg[i] <= lane_prod[i];
            end
        end
    end

    // matches in this attribute
    always_comb
    begin
        match_num = '0;
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            match_num = match_num + REQN_W'(lane_match[i]);
        end
    end

    // stage advances whenever the queue can take its content
    assign in_ready = !s1_valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = s1_valid_reg && !queue_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // flags of the staged attribute
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_match_num_reg    <= match_num;
            s1_resource_end_reg <= resource_end;
            s1_database_end_reg <= database_end;
        end
    end

    // cost added by the staged attribute, wraps at the cost width
    always_comb
    begin
        delta_sum = '0;
        for (int i = 0; i < MAX_REQUESTS; i++)
        begin
            delta_sum = delta_sum + s1_prod_reg[i];
        end
    end

    assign push_item.cost_delta   = delta_sum;
    assign push_item.match_num    = s1_match_num_reg;
    assign push_item.resource_end = s1_resource_end_reg;
    assign push_item.database_end = s1_database_end_reg;

endmodule

/* rtl/mcos_queue.sv */
// short first-in first-out queue between the front and back parts
module mcos_queue
    import mcos_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  queue_item_t push_item,
    output logic        full,
    input  logic        pop,
    output queue_item_t pop_item,
    output logic        not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/mcos_back.sv */
// back part: resource cost accumulation, best selection and result register
module mcos_back
    import mcos_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  queue_item_t       item,
    output logic              pop,
    input  logic [REQN_W-1:0] active_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [COST_W-1:0] best_cost
);

    logic [COST_W-1:0]  cost_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COST_W-1:0]  best_reg;
    logic               out_valid_reg;
    logic [COST_W-1:0]  out_data_reg;

    logic [COST_W-1:0]  cost_next;
    logic [COUNT_W-1:0] count_next;
    logic [COST_W-1:0]  best_next;
    logic               out_valid_next;

    logic [COST_W-1:0]  cost_sum;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_sat;
    logic [COST_W-1:0]  best_sel;
    logic               covers;
    logic               cheaper;
    logic               slot_free;

    // result register is free when empty or drained this cycle
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = item_valid && (!item.database_end || slot_free);

    // accumulate and pick the best resource
    assign cost_sum  = cost_reg + item.cost_delta;
    assign count_sum = {1'b0, count_reg} + (COUNT_W + 1)'(item.match_num);
    assign count_sat = (count_sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : count_sum[COUNT_W-1:0];
    assign covers    = (count_sat >= COUNT_W'(active_count));
    assign cheaper   = ($signed(cost_sum) < $signed(best_reg));
    assign best_sel  = (covers && cheaper) ? cost_sum : best_reg;

    always_comb
    begin
        cost_next      = cost_reg;
        count_next     = count_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            cost_next  = cost_sum;
            count_next = count_sat;
            if (item.resource_end || item.database_end)
            begin
                cost_next  = '0;
                count_next = '0;
                best_next  = best_sel;
            end
            if (item.database_end)
            begin
                best_next      = INT_MAX;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg      <= '0;
            count_reg     <= '0;
            best_reg      <= INT_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cost_reg      <= cost_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result data
    always_ff @(posedge clk)
    begin
        if (pop && item.database_end)
        begin
            out_data_reg <= best_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_cost = out_data_reg;

endmodule

/* rtl/min_cost_offer_select_unit.sv */
// top level of the min cost offer select unit
//
// channel   direction  signals                         contents
// s_axis    in         tvalid tready tdata tlast tuser offered attribute
// m_axis    out        tvalid tready tdata             best cost of a database
// cfg       in         cfg_we cfg_addr cfg_wdata       request registers
//
// one attribute per cycle sustained while the queue is not full; the front matches
// and multiplies, registers the products, then sums them; the back adds the cost
// and compares to the best; m_axis_tvalid rises once the attribute ending the
// database has passed the front register, the queue and the back result register
// rst_n clears the control state and sets the request count to one; the best cost restarts at the largest signed value
// the queue lets the front keep taking attributes while the back waits on
// m_axis_tready; s_axis_tready drops only once the queue is full
module min_cost_offer_select_unit
    import mcos_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // offer_unit, offer_price, offer_amount
    input  logic                  s_axis_tlast,  // database_end
    input  logic                  s_axis_tuser,  // resource_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [COST_W-1:0]     m_axis_tdata   // best_cost
);

    logic              push;
    queue_item_t       push_item;
    logic              queue_full;
    logic              pop;
    queue_item_t       pop_item;
    logic              queue_not_empty;
    logic [REQN_W-1:0] active_count;

    // unpack and classify attributes
    mcos_front #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .offer_unit   (s_axis_tdata[UNIT_W-1:0]),
        .offer_price  (s_axis_tdata[UNIT_W+PRICE_W-1:UNIT_W]),
        .offer_amount (s_axis_tdata[IN_DATA_W-1:UNIT_W+PRICE_W]),
        .resource_end (s_axis_tuser),
        .database_end (s_axis_tlast),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full),
        .active_count (active_count)
    );

    // decoupling queue
    mcos_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty)
    );

    // accumulate, select and emit
    mcos_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (queue_not_empty),
        .item         (pop_item),
        .pop          (pop),
        .active_count (active_count),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .best_cost    (m_axis_tdata)
    );

endmodule
